// File: sv/pac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pac_pkg;

    localparam int COORD_W = 20;
    localparam int SQ_W    = 2 * COORD_W + 2;
    localparam int LEN_W   = 48;
    localparam int ACC_W   = 64;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [LEN_W-1:0]        LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      first_in_line;
        logic                      reversed;
        logic                      last_in_area;
    } pac_vertex_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]   twice_area;
        logic signed [COORD_W-1:0] centroid_x;
        logic signed [COORD_W-1:0] centroid_y;
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] south;
        logic signed [COORD_W-1:0] west;
        logic                      centroid_valid;
        logic                      overflow;
    } pac_result_t;

    // returns {saturated, sum}
    function automatic logic [ACC_W:0] sat_add64(logic signed [ACC_W-1:0] a,
                                                 logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        logic                    ovf;
        s   = a + b;
        ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
        if (ovf)
        begin
            s = b[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return {ovf, s};
    endfunction

endpackage

`default_nettype wire

// File: sv/pac_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module pac_sqrt #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [pac_pkg::SQ_W-1:0]                      radicand,
    output logic                                          busy,
    output logic [pac_pkg::SQ_W/2+FRAC_BITS-1:0]          root
);
    import pac_pkg::*;

    localparam int LW = SQ_W / 2 + FRAC_BITS;
    localparam int RW = 2 * LW;
    localparam int CW = $clog2(LW + 1);

    logic [RW-1:0]   rad_reg;
    logic [LW+1:0]   rem_reg;
    logic [LW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;

    logic [LW+1:0]   rem_sh;
    logic [LW+1:0]   trial;
    logic            ge;

    // one radix-4 digit per cycle, top pair of the radicand first
    always_comb
    begin
        rem_sh = (rem_reg << 2) | (LW + 2)'(rad_reg[RW-1:RW-2]);
        trial  = {root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(LW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RW'(radicand) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[LW-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: sv/pac_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pac_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [pac_pkg::ACC_W-1:0]          dividend,
    input  logic                               negative,
    input  logic [pac_pkg::LEN_W:0]            divisor,
    output logic                               busy,
    output logic signed [pac_pkg::COORD_W-1:0] quotient
);
    import pac_pkg::*;

    localparam int QB    = COORD_W;
    localparam int DSH_W = LEN_W + 1 + QB;
    localparam int CW    = $clog2(QB + 2);

    logic [ACC_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QB-1:0]    q_reg;
    logic             big_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;

    logic             ge;
    logic             top_step;

    always_comb
    begin
        ge       = DSH_W'(rem_reg) >= dsh_reg;
        top_step = cnt_reg == CW'(QB + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(QB + 1);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // first step only detects a quotient too large for the coordinate range
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= DSH_W'(divisor) << QB;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= negative;
        end
        else if (cnt_reg != '0)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (top_step)
            begin
                big_reg <= ge;
            end
            else
            begin
                q_reg <= {q_reg[QB-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg[ACC_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (big_reg || (q_reg > {1'b1, {(QB-1){1'b0}}}))
            begin
                quotient = {1'b1, {(QB-1){1'b0}}};
            end
            else
            begin
                quotient = $signed('0 - q_reg);
            end
        end
        else
        begin
            if (big_reg || q_reg[QB-1])
            begin
                quotient = {1'b0, {(QB-1){1'b1}}};
            end
            else
            begin
                quotient = $signed(q_reg);
            end
        end
    end

    assign busy = cnt_reg != '0;

endmodule

`default_nettype wire

// File: sv/polygon_area_centroid_accumulator_unit.sv
// Polygon area and length-weighted centroid accumulator.
// vertex channel (valid/ready): one boundary vertex per beat, with line start,
// reversed and last-in-area flags. result channel (valid/ready): one beat per
// area, sent after the vertex flagged last_in_area.
// For a vertex that closes a segment, the segment length square root
// dominates, one radix-4 digit per cycle over COORD_W + 1 + LEN_FRAC_BITS
// digits, with area and weight products going through one shared
// multiplier. The last vertex of an area adds both centroid quotients,
// which run through one bit-serial divider, one quotient bit per cycle.
// vertex_ready is high only while the sequencer is idle.
// Results sit in an output register; the block keeps taking vertices while a
// result waits, and only the next area's result waits for the slot to free.
// Reset clears all accumulators, the bounding box and the output valid; there
// is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module polygon_area_centroid_accumulator_unit #(
    parameter int LEN_FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vertex_valid,
    output logic                 vertex_ready,
    input  pac_pkg::pac_vertex_t vertex,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pac_pkg::pac_result_t result
);
    import pac_pkg::*;

    localparam int LW   = SQ_W / 2 + LEN_FRAC_BITS;
    localparam int MA_W = LW + 1;
    localparam int DW   = COORD_W + 1;
    localparam int PW   = MA_W + DW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DXX,
        S_MUL_DYY,
        S_MUL_AREA,
        S_SQ_START,
        S_SQ_WAIT,
        S_MUL_WX,
        S_MUL_WY,
        S_ACC_WY,
        S_DIVX_START,
        S_DIVX_WAIT,
        S_DIVY_START,
        S_DIVY_WAIT,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic                      have_prev_reg, line_neg_reg, last_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg, sx_reg, sy_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [LW-1:0]             len_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [ACC_W-1:0]   area_reg, wsx_reg, wsy_reg;
    logic [LEN_W-1:0]          len_sum_reg;
    logic signed [COORD_W-1:0] north_reg, east_reg, south_reg, west_reg;
    logic                      box_seen_reg, sat_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic                      result_valid_reg;
    pac_result_t               result_reg;

    logic                      accept, seg_in, emit_fire;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [DW-1:0]      mul_b;
    logic signed [PW-1:0]      prod_next;
    logic signed [ACC_W-1:0]   prod64, area_term;
    logic [ACC_W:0]            area_add, wsx_add, wsy_add;
    logic [LEN_W:0]            len_add;
    logic signed [ACC_W-1:0]   div_w;
    logic [ACC_W-1:0]          div_mag;
    logic                      sq_start, sq_busy, dv_start, dv_busy;
    logic [LW-1:0]             sq_root;
    logic signed [COORD_W-1:0] dv_q;
    logic                      cen_valid;

    assign vertex_ready = state_reg == S_IDLE;
    assign accept       = vertex_valid && vertex_ready;
    assign seg_in       = have_prev_reg && !vertex.first_in_line;
    assign emit_fire    = (state_reg == S_EMIT) && (!result_valid_reg || result_ready);
    assign cen_valid    = len_sum_reg != '0;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_DXX:
            begin
                mul_a = MA_W'(dx_reg);
                mul_b = dx_reg;
            end
            S_MUL_DYY:
            begin
                mul_a = MA_W'(dy_reg);
                mul_b = dy_reg;
            end
            S_MUL_AREA:
            begin
                mul_a = MA_W'(dx_reg);
                mul_b = sy_reg;
            end
            S_MUL_WX:
            begin
                mul_a = $signed({1'b0, len_reg});
                mul_b = sx_reg;
            end
            S_MUL_WY:
            begin
                mul_a = $signed({1'b0, len_reg});
                mul_b = sy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        prod64    = ACC_W'(prod_reg);
        area_term = line_neg_reg ? -prod64 : prod64;
        area_add  = sat_add64(area_reg, area_term);
        wsx_add   = sat_add64(wsx_reg, prod64);
        wsy_add   = sat_add64(wsy_reg, prod64);
        len_add   = {1'b0, len_sum_reg} + (LEN_W + 1)'(len_reg);
        div_w     = (state_reg == S_DIVY_START) ? wsy_reg : wsx_reg;
        div_mag   = div_w[ACC_W-1] ? ('0 - div_w) : div_w;
        sq_start  = state_reg == S_SQ_START;
        dv_start  = (state_reg == S_DIVX_START) || (state_reg == S_DIVY_START);
    end

    pac_sqrt #(
        .FRAC_BITS (LEN_FRAC_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_reg),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    pac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (div_mag),
        .negative (div_w[ACC_W-1]),
        .divisor  ({len_sum_reg, 1'b0}),
        .busy     (dv_busy),
        .quotient (dv_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            have_prev_reg    <= 1'b0;
            line_neg_reg     <= 1'b0;
            area_reg         <= '0;
            wsx_reg          <= '0;
            wsy_reg          <= '0;
            len_sum_reg      <= '0;
            north_reg        <= '0;
            east_reg         <= '0;
            south_reg        <= '0;
            west_reg         <= '0;
            box_seen_reg     <= 1'b0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            prod_reg <= prod_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_x_reg <= vertex.x;
                        prev_y_reg <= vertex.y;
                        last_reg   <= vertex.last_in_area;
                        dx_reg     <= DW'($signed(vertex.x)) - DW'(prev_x_reg);
                        dy_reg     <= DW'($signed(vertex.y)) - DW'(prev_y_reg);
                        sx_reg     <= DW'($signed(vertex.x)) + DW'(prev_x_reg);
                        sy_reg     <= DW'($signed(vertex.y)) + DW'(prev_y_reg);
                        if (seg_in)
                        begin
                            // box tracks segment start points
                            box_seen_reg <= 1'b1;
                            if (!box_seen_reg || (prev_y_reg > north_reg))
                            begin
                                north_reg <= prev_y_reg;
                            end
                            if (!box_seen_reg || (prev_x_reg > east_reg))
                            begin
                                east_reg <= prev_x_reg;
                            end
                            if (!box_seen_reg || (prev_y_reg < south_reg))
                            begin
                                south_reg <= prev_y_reg;
                            end
                            if (!box_seen_reg || (prev_x_reg < west_reg))
                            begin
                                west_reg <= prev_x_reg;
                            end
                            state_reg <= S_MUL_DXX;
                        end
                        else
                        begin
                            line_neg_reg  <= vertex.reversed;
                            have_prev_reg <= 1'b1;
                            state_reg     <= vertex.last_in_area ? S_DIVX_START : S_IDLE;
                        end
                    end
                end
                S_MUL_DXX:
                begin
                    state_reg <= S_MUL_DYY;
                end
                S_MUL_DYY:
                begin
                    sq_reg    <= prod_reg[SQ_W-1:0];
                    state_reg <= S_MUL_AREA;
                end
                S_MUL_AREA:
                begin
                    sq_reg    <= sq_reg + prod_reg[SQ_W-1:0];
                    state_reg <= S_SQ_START;
                end
                S_SQ_START:
                begin
                    area_reg  <= area_add[ACC_W-1:0];
                    sat_reg   <= sat_reg | area_add[ACC_W];
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (!sq_busy)
                    begin
                        len_reg   <= sq_root;
                        state_reg <= S_MUL_WX;
                    end
                end
                S_MUL_WX:
                begin
                    state_reg <= S_MUL_WY;
                end
                S_MUL_WY:
                begin
                    wsx_reg   <= wsx_add[ACC_W-1:0];
                    sat_reg   <= sat_reg | wsx_add[ACC_W];
                    state_reg <= S_ACC_WY;
                end
                S_ACC_WY:
                begin
                    wsy_reg <= wsy_add[ACC_W-1:0];
                    if (len_add[LEN_W])
                    begin
                        len_sum_reg <= LEN_MAX;
                    end
                    else
                    begin
                        len_sum_reg <= len_add[LEN_W-1:0];
                    end
                    sat_reg   <= sat_reg | wsy_add[ACC_W] | len_add[LEN_W];
                    state_reg <= last_reg ? S_DIVX_START : S_IDLE;
                end
                S_DIVX_START:
                begin
                    state_reg <= S_DIVX_WAIT;
                end
                S_DIVX_WAIT:
                begin
                    if (!dv_busy)
                    begin
                        cx_reg    <= dv_q;
                        state_reg <= S_DIVY_START;
                    end
                end
                S_DIVY_START:
                begin
                    state_reg <= S_DIVY_WAIT;
                end
                S_DIVY_WAIT:
                begin
                    if (!dv_busy)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        result_reg.twice_area     <= area_reg;
                        result_reg.centroid_x     <= cen_valid ? cx_reg : '0;
                        result_reg.centroid_y     <= cen_valid ? dv_q : '0;
                        result_reg.north          <= north_reg;
                        result_reg.east           <= east_reg;
                        result_reg.south          <= south_reg;
                        result_reg.west           <= west_reg;
                        result_reg.centroid_valid <= cen_valid;
                        result_reg.overflow       <= sat_reg;
                        // per-area state back to empty
                        have_prev_reg <= 1'b0;
                        line_neg_reg  <= 1'b0;
                        area_reg      <= '0;
                        wsx_reg       <= '0;
                        wsy_reg       <= '0;
                        len_sum_reg   <= '0;
                        north_reg     <= '0;
                        east_reg      <= '0;
                        south_reg     <= '0;
                        west_reg      <= '0;
                        box_seen_reg  <= 1'b0;
                        sat_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no vertex is taken while the root unit still works on a segment
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_ready |-> !sq_busy)
        else $error("vertex ready while square root busy");

    // root and divider never run together under the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_busy && dv_busy))
        else $error("square root and divider busy together");

    // a vertex closing a segment holds off the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && have_prev_reg && !vertex.first_in_line
        |=> !vertex_ready)
        else $error("segment vertex did not stall input");

    // zero total length gives a zero centroid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.centroid_valid
        |-> (result.centroid_x == '0) && (result.centroid_y == '0))
        else $error("centroid not zero for zero length");

endmodule

`default_nettype wire
